@@ rtl/tbc_pkg.sv @@
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants of the thermostat band controller
// field widths, register indexes and reset values, item kinds, controller
// states, and the command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package tbc_pkg;

  // field widths
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned ADC_W      = 10;
  localparam int unsigned TEMP_W     = 9;
  localparam int unsigned MARGIN_W   = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 32;

  // default parameter values
  localparam int unsigned RING_DEPTH_DEF    = 10;
  localparam int unsigned SETPOINT_STEP_DEF = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_MARGIN      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SETPOINT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SETPOINT     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SETPOINT = 2'd3;

  // register reset values
  localparam logic [MARGIN_W-1:0] BAND_MARGIN_RST      = 6'd2;
  localparam logic [TEMP_W-1:0]   MIN_SETPOINT_RST     = 9'd35;
  localparam logic [TEMP_W-1:0]   MAX_SETPOINT_RST     = 9'd75;
  localparam logic [TEMP_W-1:0]   INITIAL_SETPOINT_RST = 9'd60;
  localparam logic [TEMP_W-1:0]   TEMP_MAX             = 9'd511;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE  = 2'd0,
    FUNC_CONTROL = 2'd1,
    FUNC_RAISE   = 2'd2,
    FUNC_LOWER   = 2'd3
  } func_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_READ,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIV,
    ST_ADJUST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic fill_step;
    logic rd_old;
    logic upd;
    logic div_init;
    logic div_step;
    logic sp_adj;
    logic emit;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  filled;
    logic  fill_last;
    logic  out_free;
  } status_t;

endpackage

@@ rtl/thermostat_band_controller.sv @@
// ----------------------------------------------------------------------------
// thermostat_band_controller: dead-band thermostat on a moving average
// state path: control item decode, done; set-point item decode, adjust, done;
//   sample decode, read, update, divide init, divide, done; the first sample
//   decode, fill the whole ring, done; one item at a time, next beat taken the
//   cycle after the result is registered; a stalled result waits
// reset: asynchronous, active low; registers load defaults, set-point 60,
//   ring marked empty, mean and latest temperature zero
// ----------------------------------------------------------------------------
module thermostat_band_controller #(
  parameter int unsigned RING_DEPTH    = tbc_pkg::RING_DEPTH_DEF,
  parameter int unsigned SETPOINT_STEP = tbc_pkg::SETPOINT_STEP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [tbc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input beats
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // adc_sample[9:0], blink_phase[10], zero pad
  input  logic [tbc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [tbc_pkg::FUNC_W-1:0]     s_axis_tuser,
  // result beats
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // heater_on[0], cooler_on[1], led_on[2], average_temp[11:3],
  // setpoint_now[20:12], display_value[29:21], display_blank[30], zero pad
  output logic [tbc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // command and status between sequencer and datapath
  tbc_pkg::cmd_t    cmd;
  tbc_pkg::status_t status;

  // sequencer: one item in flight, output register frees the input side
  tbc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  // datapath: ring memory, running sum, reciprocal divide, band compare
  tbc_dp #(
    .RING_DEPTH    (RING_DEPTH),
    .SETPOINT_STEP (SETPOINT_STEP)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule

@@ rtl/tbc_ram.sv @@
// ----------------------------------------------------------------------------
// tbc_ram: generic single-write, single-read ram
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module tbc_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/tbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbc_ctrl: controller state machine
// sequences one item at a time through fill, ring update, divide, set-point adjust and result
// ----------------------------------------------------------------------------
module tbc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  tbc_pkg::status_t status_i,
  output tbc_pkg::cmd_t    cmd_o
);

  tbc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tbc_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = tbc_pkg::ST_DECODE;
        end
      end
      tbc_pkg::ST_DECODE: begin
        case (status_i.func)
          tbc_pkg::FUNC_SAMPLE:  state_d = status_i.filled ? tbc_pkg::ST_READ
                                                          : tbc_pkg::ST_FILL;
          tbc_pkg::FUNC_CONTROL: state_d = tbc_pkg::ST_DONE;
          default:               state_d = tbc_pkg::ST_ADJUST;
        endcase
      end
      tbc_pkg::ST_FILL: begin
        if (status_i.fill_last) begin
          state_d = tbc_pkg::ST_DONE;
        end
      end
      tbc_pkg::ST_READ:     state_d = tbc_pkg::ST_UPDATE;
      tbc_pkg::ST_UPDATE:   state_d = tbc_pkg::ST_DIV_INIT;
      tbc_pkg::ST_DIV_INIT: state_d = tbc_pkg::ST_DIV;
      tbc_pkg::ST_DIV:      state_d = tbc_pkg::ST_DONE;
      tbc_pkg::ST_ADJUST:   state_d = tbc_pkg::ST_DONE;
      tbc_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          state_d = tbc_pkg::ST_IDLE;
        end
      end
      default:              state_d = tbc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      tbc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.load    = s_axis_tvalid;
      end
      tbc_pkg::ST_FILL:     cmd_o.fill_step = 1'b1;
      tbc_pkg::ST_READ:     cmd_o.rd_old    = 1'b1;
      tbc_pkg::ST_UPDATE:   cmd_o.upd       = 1'b1;
      tbc_pkg::ST_DIV_INIT: cmd_o.div_init  = 1'b1;
      tbc_pkg::ST_DIV:      cmd_o.div_step  = 1'b1;
      tbc_pkg::ST_ADJUST:   cmd_o.sp_adj    = 1'b1;
      tbc_pkg::ST_DONE:     cmd_o.emit      = status_i.out_free;
      default: ;
    endcase
  end

endmodule

@@ rtl/tbc_dp.sv @@
// ----------------------------------------------------------------------------
// tbc_dp: datapath of the thermostat band controller
// config registers, sample ring with running sum, reciprocal-multiply mean,
// set-point adjust, band decision and output register
// ----------------------------------------------------------------------------
module tbc_dp #(
  parameter int unsigned RING_DEPTH    = tbc_pkg::RING_DEPTH_DEF,
  parameter int unsigned SETPOINT_STEP = tbc_pkg::SETPOINT_STEP_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [tbc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic [tbc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic [tbc_pkg::FUNC_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [tbc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  tbc_pkg::cmd_t                     cmd_i,
  output tbc_pkg::status_t                  status_o
);

  localparam int unsigned TW     = tbc_pkg::TEMP_W;
  localparam int unsigned IDX_W  = $clog2(RING_DEPTH);
  localparam int unsigned SUM_W  = $clog2(RING_DEPTH * ((2 ** TW) - 1) + 1);
  localparam int unsigned CW     = TW + 2;
  // mean = (sum * RCP) >> RCP_SH, exact for every sum below 2 ** SUM_W
  localparam int unsigned RCP_SH = SUM_W + IDX_W;
  localparam int unsigned RCP_W  = SUM_W + 1;
  localparam int unsigned PROD_W = SUM_W + RCP_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(RING_DEPTH - 1);
  localparam logic [RCP_W-1:0] RCP      =
    RCP_W'(((2 ** RCP_SH) + RING_DEPTH - 1) / RING_DEPTH);
  localparam logic [SUM_W:0]   DEPTH_S  = (SUM_W + 1)'(RING_DEPTH);
  localparam logic [TW-1:0]    STEP_T   = TW'(SETPOINT_STEP);

  // configuration
  logic [tbc_pkg::MARGIN_W-1:0] band_q;
  logic [TW-1:0]                min_sp_q, max_sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q   <= tbc_pkg::BAND_MARGIN_RST;
      min_sp_q <= tbc_pkg::MIN_SETPOINT_RST;
      max_sp_q <= tbc_pkg::MAX_SETPOINT_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        tbc_pkg::CFG_BAND_MARGIN:  band_q   <= cfg_wdata_i[tbc_pkg::MARGIN_W-1:0];
        tbc_pkg::CFG_MIN_SETPOINT: min_sp_q <= cfg_wdata_i[TW-1:0];
        tbc_pkg::CFG_MAX_SETPOINT: max_sp_q <= cfg_wdata_i[TW-1:0];
        // only seen through reset, which reloads its default anyway
        tbc_pkg::CFG_INITIAL_SETPOINT: ;
        default: ;
      endcase
    end
  end

  // item capture
  tbc_pkg::func_e func_q;
  logic           blink_q;
  logic [TW-1:0]  latest_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latest_q <= '0;
    end else if (cmd_i.load && (tbc_pkg::func_e'(s_axis_tuser) == tbc_pkg::FUNC_SAMPLE)) begin
      latest_q <= s_axis_tdata[tbc_pkg::ADC_W-1:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= tbc_pkg::func_e'(s_axis_tuser);
      blink_q <= s_axis_tdata[tbc_pkg::ADC_W];
    end
  end

  // sample ring and running sum
  logic             filled_q;
  logic [IDX_W-1:0] idx_q;
  logic [SUM_W-1:0] sum_q;
  logic [TW-1:0]    old_rd;
  logic             ring_we;

  assign ring_we = cmd_i.fill_step || cmd_i.upd;

  tbc_ram #(
    .WIDTH (TW),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (idx_q),
    .wdata_i (latest_q),
    .re_i    (cmd_i.rd_old),
    .raddr_i (idx_q),
    .rdata_o (old_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
      idx_q    <= '0;
      sum_q    <= '0;
    end else begin
      if (ring_we) begin
        idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
      end
      if (cmd_i.fill_step) begin
        sum_q <= sum_q + SUM_W'(latest_q);
        if (idx_q == IDX_LAST) begin
          filled_q <= 1'b1;
        end
      end else if (cmd_i.upd) begin
        sum_q <= sum_q - SUM_W'(old_rd) + SUM_W'(latest_q);
      end
    end
  end

  // divide by the ring depth: registered product, then the quotient bits
  logic [PROD_W-1:0] prod_q;
  logic [TW-1:0]     mean_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      prod_q <= PROD_W'(sum_q) * PROD_W'(RCP);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= '0;
    end else if (cmd_i.fill_step && (idx_q == IDX_LAST)) begin
      // every entry holds the same sample
      mean_q <= latest_q;
    end else if (cmd_i.div_step) begin
      mean_q <= prod_q[RCP_SH +: TW];
    end
  end

  // set-point adjust
  logic [TW-1:0] sp_q, sp_up, sp_dn;
  logic [TW:0]   sp_add;

  assign sp_add = {1'b0, sp_q} + {1'b0, STEP_T};
  assign sp_up  = sp_add[TW] ? tbc_pkg::TEMP_MAX : sp_add[TW-1:0];
  assign sp_dn  = (sp_q >= STEP_T) ? sp_q - STEP_T : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= tbc_pkg::INITIAL_SETPOINT_RST;
    end else if (cmd_i.sp_adj) begin
      if ((func_q == tbc_pkg::FUNC_RAISE) && (sp_q < max_sp_q)) begin
        sp_q <= sp_up;
      end else if ((func_q == tbc_pkg::FUNC_LOWER) && (sp_q > min_sp_q)) begin
        sp_q <= sp_dn;
      end
    end
  end

  // band decision, signed
  logic signed [CW-1:0] sp_s, hi_s, lo_s;
  logic                 below_hi, in_band, ctl_item;
  logic                 heat, cool, led, blank;
  logic [TW-1:0]        disp;

  assign sp_s     = $signed({2'b00, sp_q});
  assign hi_s     = $signed({2'b00, mean_q}) + $signed({{(CW - tbc_pkg::MARGIN_W){1'b0}}, band_q});
  assign lo_s     = $signed({2'b00, mean_q}) - $signed({{(CW - tbc_pkg::MARGIN_W){1'b0}}, band_q});
  assign below_hi = sp_s < hi_s;
  assign in_band  = below_hi && (sp_s > lo_s);
  assign ctl_item = (func_q == tbc_pkg::FUNC_SAMPLE) || (func_q == tbc_pkg::FUNC_CONTROL);

  assign heat  = ctl_item && !below_hi;
  assign cool  = ctl_item && !in_band && below_hi;
  assign led   = cool || (heat && blink_q);
  assign blank = !ctl_item && !blink_q;
  assign disp  = ctl_item ? latest_q : sp_q;

  // output register
  logic                          out_valid_q;
  logic [tbc_pkg::OUT_DATA_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= {1'b0, blank, disp, sp_q, mean_q, led, cool, heat};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign status_o.func      = func_q;
  assign status_o.filled    = filled_q;
  assign status_o.fill_last = idx_q == IDX_LAST;
  assign status_o.out_free  = !out_valid_q || m_axis_tready;

  // ring pointer never leaves the ring
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_LAST)
    else $error("ring index out of range");

  // the new mean is the truncated quotient of the ring sum
  a_mean_exact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=>
      (((SUM_W + 1)'(mean_q) * DEPTH_S) <= (SUM_W + 1)'(sum_q)) &&
      ((SUM_W + 1)'(sum_q) < (((SUM_W + 1)'(mean_q) + 1'b1) * DEPTH_S)))
    else $error("mean does not match ring sum");

  // a raise at or above the limit leaves the set-point alone
  a_raise_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.sp_adj && (func_q == tbc_pkg::FUNC_RAISE) && (sp_q >= max_sp_q))
      |=> $stable(sp_q))
    else $error("set-point raised past limit");

  // a taken beat with no new result drops valid
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready && !cmd_i.emit) |=> !out_valid_q)
    else $error("result beat repeated");

endmodule
